/* rtl/ppu_pkg.sv */
// Shared types, constants and a helper function of the video processor register port.
package ppu_pkg;

    localparam int VIDEO_WORDS = 16384;
    localparam int VADDR_W     = $clog2(VIDEO_WORDS);

    localparam logic [VADDR_W-1:0] MIRROR_LO   = VADDR_W'(16'h3000);
    localparam logic [VADDR_W-1:0] MIRROR_HI   = VADDR_W'(16'h3EFF);
    localparam logic [VADDR_W-1:0] MIRROR_DROP = VADDR_W'(16'h1000);
    localparam logic [VADDR_W-1:0] PALETTE_LO  = VADDR_W'(16'h3F00);
    localparam logic [VADDR_W-1:0] PALETTE_HI  = VADDR_W'(16'h3FFF);
    localparam logic [VADDR_W-1:0] STEP_ROW    = VADDR_W'(32);
    localparam logic [VADDR_W-1:0] STEP_ONE    = VADDR_W'(1);

    // Access modes carried in the low bits of tuser.
    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_VBL_ON  = 2'd2,
        MODE_VBL_OFF = 2'd3
    } mode_t;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_idx_t;

    // Operations after classification by the front end.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_STATUS_RD,
        OP_DATA_RD,
        OP_CTRL_WR,
        OP_MASK_WR,
        OP_SCROLL_WR,
        OP_ADDR_WR,
        OP_DATA_WR,
        OP_VBL_SET,
        OP_VBL_CLR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [7:0] scroll_y_value;
        logic [7:0] scroll_x_value;
        logic [7:0] mask_value;
        logic [7:0] control_value;
        logic       nmi_pulse;
        logic [7:0] read_data;
    } res_t;

    localparam int RES_W   = $bits(res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    function automatic logic [VADDR_W-1:0] mirror_down(input logic [VADDR_W-1:0] a);
        logic [VADDR_W-1:0] r;
        r = a;
        if (a >= MIRROR_LO && a <= MIRROR_HI) begin
            r = a - MIRROR_DROP;
        end
        return r;
    endfunction

endpackage

/* rtl/ppu_register_port.sv */
// Top level of the processor-side register port of the tile video processor.
//
//  Channel | Direction | Word contents (lowest bits first)
//  --------+-----------+-----------------------------------------------------------
//  s_      | in        | tuser: mode[1:0], reg_index[4:2]; tdata: write_data[7:0]
//  m_      | out       | tdata: read_data[7:0], nmi_pulse[8], control_value[16:9],
//          |           |        mask_value[24:17], scroll_x_value[32:25],
//          |           |        scroll_y_value[40:33], zero fill [47:41]
//
// Every accepted input word produces exactly one result word, in order.
// A data register read occupies the back end until its byte has left the registered
// read port of the 16K-byte video memory; every other word is finished when taken, so
// such words stream at one per cycle while m_tready stays high. A result word becomes
// valid once its input word has passed the queue and the result register.
// After reset the video memory is cleared one byte per cycle: s_tready stays low until
// every byte is cleared. A two-entry queue separates the front end from the back end,
// so up to two input words are still accepted while a finished result waits on m_tready.
module ppu_register_port (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [4:0]  s_tuser,   // mode[1:0], reg_index[4:2]
    input  logic [7:0]  s_tdata,   // write_data[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ppu_pkg::M_TDATA_W-1:0] m_tdata  // read_data, nmi_pulse, control_value,
                                                   // mask_value, scroll_x_value,
                                                   // scroll_y_value, zero fill
);
    import ppu_pkg::*;

    q_stat_t q_stat;
    cmd_t    push_cmd;
    cmd_t    head;
    logic    push;
    logic    pop;
    logic    clr_busy;
    res_t    res;

    // The front end only decodes; it holds no state of its own.
    ppu_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .clr_busy (clr_busy),
        .push     (push),
        .cmd      (push_cmd)
    );

    ppu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // The back end owns all architectural state and the result register.
    ppu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .clr_busy (clr_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {(M_TDATA_W - RES_W)'(0), res};

endmodule

/* rtl/ppu_front.sv */
// Front end: accepts bus words and classifies them into back-end operations.
module ppu_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [4:0]        s_tuser,
    input  logic [7:0]        s_tdata,
    input  ppu_pkg::q_stat_t  q_stat,
    input  logic              clr_busy,
    output logic              push,
    output ppu_pkg::cmd_t     cmd
);
    import ppu_pkg::*;

    mode_t    mode;
    reg_idx_t ridx;

    assign mode = mode_t'(s_tuser[1:0]);
    assign ridx = reg_idx_t'(s_tuser[4:2]);

    assign s_tready = !q_stat.full && !clr_busy;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        cmd.data = s_tdata;
        cmd.op   = OP_NONE;
        unique case (mode)
            MODE_READ: begin
                unique case (ridx)
                    REG_STATUS: cmd.op = OP_STATUS_RD;
                    REG_DATA:   cmd.op = OP_DATA_RD;
                    default:    cmd.op = OP_NONE;
                endcase
            end
            MODE_WRITE: begin
                // Sprite address only feeds sprite memory, which is not part of this port.
                unique case (ridx)
                    REG_CTRL:   cmd.op = OP_CTRL_WR;
                    REG_MASK:   cmd.op = OP_MASK_WR;
                    REG_SCROLL: cmd.op = OP_SCROLL_WR;
                    REG_ADDR:   cmd.op = OP_ADDR_WR;
                    REG_DATA:   cmd.op = OP_DATA_WR;
                    default:    cmd.op = OP_NONE;
                endcase
            end
            MODE_VBL_ON:  cmd.op = OP_VBL_SET;
            MODE_VBL_OFF: cmd.op = OP_VBL_CLR;
            default:      cmd.op = OP_NONE;
        endcase
    end

endmodule

/* rtl/ppu_queue.sv */
// Two-entry command queue between the front end and the back end.
module ppu_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ppu_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output ppu_pkg::cmd_t     head,
    output ppu_pkg::q_stat_t  stat
);
    import ppu_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = (count_reg == 2'd2);

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/ppu_back.sv */
// Back end: register file, video memory with its clearing pass, and the result register.
module ppu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ppu_pkg::q_stat_t  q_stat,
    input  ppu_pkg::cmd_t     head,
    output logic              pop,
    output logic              clr_busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ppu_pkg::res_t     m_res
);
    import ppu_pkg::*;

    logic [7:0] mem [VIDEO_WORDS];

    logic [VADDR_W-1:0] vaddr_reg, vaddr_next;
    logic               addr_lo_reg, addr_lo_next;
    logic               sy_next_reg, sy_next_next;
    logic [7:0]         buf_reg, buf_next;
    logic [7:0]         ctrl_reg, ctrl_next;
    logic [7:0]         mask_reg, mask_next;
    logic [7:0]         sx_reg, sx_next;
    logic [7:0]         sy_reg, sy_next;
    logic               vbl_reg, vbl_next;
    logic               pend_reg, pend_next;
    logic               pal_reg, pal_next;
    logic               clr_reg, clr_next;
    logic [VADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic               mvalid_reg, mvalid_next;
    res_t               res_reg, res_next;
    logic [7:0]         rdq_reg;

    logic               out_free;
    logic               finish;
    logic [VADDR_W-1:0] mirr, step;
    logic               mem_we, mem_re;
    logic [VADDR_W-1:0] mem_waddr;
    logic [7:0]         mem_wdata;
    logic [7:0]         rd_val;
    logic               nmi_val;
    logic               emit;

    assign out_free = !mvalid_reg || m_tready;
    assign pop      = q_stat.valid && !pend_reg && !clr_reg && out_free;
    assign finish   = pend_reg && out_free;
    assign clr_busy = clr_reg;
    assign m_tvalid = mvalid_reg;
    assign m_res    = res_reg;
    assign mirr     = mirror_down(vaddr_reg);
    assign step     = ctrl_reg[2] ? STEP_ROW : STEP_ONE;

    always_comb begin
        vaddr_next    = vaddr_reg;
        addr_lo_next  = addr_lo_reg;
        sy_next_next  = sy_next_reg;
        buf_next      = buf_reg;
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        vbl_next      = vbl_reg;
        pend_next     = pend_reg;
        pal_next      = pal_reg;
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = mirr;
        mem_wdata     = head.data;
        rd_val        = 8'd0;
        nmi_val       = 1'b0;
        emit          = 1'b0;

        if (clr_reg) begin
            mem_we        = 1'b1;
            mem_waddr     = clr_addr_reg;
            mem_wdata     = 8'd0;
            clr_addr_next = clr_addr_reg + STEP_ONE;
            if (clr_addr_reg == VADDR_W'(VIDEO_WORDS - 1)) begin
                clr_next = 1'b0;
            end
        end

        if (finish) begin
            // Completion of a data read: memory byte is now registered.
            rd_val    = pal_reg ? rdq_reg : buf_reg;
            buf_next  = rdq_reg;
            pend_next = 1'b0;
            emit      = 1'b1;
        end

        if (pop) begin
            emit = 1'b1;
            unique case (head.op)
                OP_STATUS_RD: begin
                    rd_val       = {vbl_reg, 7'd0};
                    vbl_next     = 1'b0;
                    addr_lo_next = 1'b0;
                    sy_next_next = 1'b0;
                end
                OP_DATA_RD: begin
                    mem_re     = 1'b1;
                    pal_next   = (mirr >= PALETTE_LO) && (mirr <= PALETTE_HI);
                    pend_next  = 1'b1;
                    vaddr_next = mirr + step;
                    emit       = 1'b0;
                end
                OP_CTRL_WR: begin
                    nmi_val   = !ctrl_reg[7] && vbl_reg && head.data[7];
                    ctrl_next = head.data;
                end
                OP_MASK_WR: mask_next = head.data;
                OP_SCROLL_WR: begin
                    if (sy_next_reg) begin
                        sy_next = head.data;
                    end else begin
                        sx_next = head.data;
                    end
                    sy_next_next = !sy_next_reg;
                end
                OP_ADDR_WR: begin
                    if (addr_lo_reg) begin
                        vaddr_next = mirror_down({vaddr_reg[VADDR_W-1:8], head.data});
                    end else begin
                        vaddr_next = {head.data[VADDR_W-9:0], 8'd0};
                    end
                    addr_lo_next = !addr_lo_reg;
                end
                OP_DATA_WR: begin
                    mem_we     = 1'b1;
                    vaddr_next = mirr + step;
                end
                OP_VBL_SET: vbl_next = 1'b1;
                OP_VBL_CLR: vbl_next = 1'b0;
                default: ;
            endcase
        end

        mvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);
        res_next    = res_reg;
        if (emit) begin
            res_next.read_data      = rd_val;
            res_next.nmi_pulse      = nmi_val;
            res_next.control_value  = ctrl_next;
            res_next.mask_value     = mask_next;
            res_next.scroll_x_value = sx_next;
            res_next.scroll_y_value = sy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vaddr_reg    <= '0;
            addr_lo_reg  <= 1'b0;
            sy_next_reg  <= 1'b0;
            buf_reg      <= 8'd0;
            ctrl_reg     <= 8'd0;
            mask_reg     <= 8'd0;
            sx_reg       <= 8'd0;
            sy_reg       <= 8'd0;
            vbl_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            pal_reg      <= 1'b0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            vaddr_reg    <= vaddr_next;
            addr_lo_reg  <= addr_lo_next;
            sy_next_reg  <= sy_next_next;
            buf_reg      <= buf_next;
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            vbl_reg      <= vbl_next;
            pend_reg     <= pend_next;
            pal_reg      <= pal_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdq_reg <= mem[mirr];
        end
    end

endmodule

/* rtl/ppu_port_check.sv */
// Port-level checker for the register port, bound to the top level.
module ppu_port_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset starts the memory clearing pass, so no input word can be taken right after it.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // Reset empties the result register.
    a_out_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // An interrupt pulse only comes from a control write that sets the enable bit,
    // and such a write returns no read data.
    a_nmi_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[16] && (m_tdata[7:0] == 8'd0))
        else $error("interrupt pulse without a control write enabling it");

endmodule

bind ppu_register_port ppu_port_check u_ppu_port_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
